FILE: design/bm3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bm3_pkg: shared constants and types for the 3x3 binary morphology block
// Register indexes, operation codes, field widths and the control structs
// passed between the top level and the filter stages.
// ----------------------------------------------------------------------------
package bm3_pkg;

  // Default line length limit
  localparam int MAX_WIDTH_DEF = 1024;

  // Frame height limit and counter widths
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int HGT_W      = 13;

  // Field widths
  localparam int PIX_W      = 8;
  localparam int CFG_WID_W  = 11;
  localparam int CFG_MODE_W = 2;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OPER_MODE    = 2'd2;

  // Operation modes
  localparam logic [CFG_MODE_W-1:0] MODE_DILATE = 2'd0;
  localparam logic [CFG_MODE_W-1:0] MODE_ERODE  = 2'd1;
  localparam logic [CFG_MODE_W-1:0] MODE_OPEN   = 2'd2;
  localparam logic [CFG_MODE_W-1:0] MODE_CLOSE  = 2'd3;

  // Register reset values
  localparam logic [CFG_WID_W-1:0]  WIDTH_RST  = 11'd640;
  localparam logic [HGT_W-1:0]      HEIGHT_RST = 13'd480;
  localparam logic [CFG_MODE_W-1:0] MODE_RST   = MODE_DILATE;

  // Value written for a set foreground pixel
  localparam logic [PIX_W-1:0] FG_VALUE = 8'd255;

  // Per-stage control, one set per item
  typedef struct packed {
    logic acc;     // item accepted at this edge
    logic adv;     // item in the compute register leaves at this edge
    logic step;    // stage takes part in this item
    logic flush;   // stage sees this item as a flush
    logic dilate;  // stage dilates (else erodes)
  } bm3_ctl_t;

  // Per-stage result status of the item in the compute register
  typedef struct packed {
    logic emit;    // stage produces a pixel
    logic last;    // pixel closes the frame
  } bm3_res_t;

endpackage

`default_nettype wire

FILE: design/bm3_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bm3_stage: one 3x3 dilate/erode stage
// Two line memories, a 3x3 window, input and output raster counters and a
// fill count. Control is decided when the item is accepted; the pixel math
// runs on the registered line data while the item sits in the compute
// register.
// ----------------------------------------------------------------------------
module bm3_stage #(
  parameter int MAX_WIDTH = bm3_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]    width_i,
  input  wire logic [bm3_pkg::HGT_W-1:0]         height_i,
  input  wire bm3_pkg::bm3_ctl_t                 ctl_i,
  input  wire logic [bm3_pkg::PIX_W-1:0]         pix_i,
  output logic                                   emit_o,
  output bm3_pkg::bm3_res_t                      res_o,
  output logic [bm3_pkg::PIX_W-1:0]              pix_o
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
  localparam int FILL_W = $clog2(MAX_WIDTH + 3);
  localparam int ROW_W  = bm3_pkg::ROW_W;
  localparam int HGT_W  = bm3_pkg::HGT_W;
  localparam int PIX_W  = bm3_pkg::PIX_W;

  // Raster counters and fill count
  logic [COL_W-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [ROW_W-1:0]  in_row_q, in_row_d, out_row_q, out_row_d;
  logic [FILL_W-1:0] fill_q, fill_d;

  // Accept-time decode
  logic [COL_W-1:0]  c_clamp, oc_clamp, in_col_nx, out_col_nx, rd_addr;
  logic [ROW_W-1:0]  r_clamp, or_clamp, in_row_nx, out_row_nx;
  logic [HGT_W-1:0]  in_row_inc, out_row_inc;
  logic              in_col_end, out_col_end;
  logic [FILL_W-1:0] fill_inc, fill_cap;
  logic              norm_emit, flush_emit;
  logic              on_last_row, on_last_col, interior;
  logic              rd_en;

  // Compute register
  logic              s1_step_q, s1_emit_q;
  logic              s1_flush_q, s1_int_q, s1_last_q, s1_sel_q;
  logic [COL_W-1:0]  s1_addr_q;

  // Line memories and window
  logic [PIX_W-1:0]  line0_mem [MAX_WIDTH];
  logic [PIX_W-1:0]  line1_mem [MAX_WIDTH];
  logic [PIX_W-1:0]  rd0_q, rd1_q;
  logic [8:0][PIX_W-1:0] win_q, win_nx;
  logic              wr_en;
  logic              any_set, any_clear;
  logic [PIX_W-1:0]  center, morph;

  // Clamp positions to the current frame size and work out the next ones
  always_comb begin
    c_clamp  = (WEFF_W'(in_col_q) >= width_i)  ? '0 : in_col_q;
    r_clamp  = (HGT_W'(in_row_q) >= height_i)  ? '0 : in_row_q;
    oc_clamp = (WEFF_W'(out_col_q) >= width_i) ? '0 : out_col_q;
    or_clamp = (HGT_W'(out_row_q) >= height_i) ? '0 : out_row_q;

    in_col_end  = (WEFF_W'(c_clamp) + WEFF_W'(1)) >= width_i;
    in_row_inc  = HGT_W'(r_clamp) + HGT_W'(1);
    in_col_nx   = in_col_end ? '0 : c_clamp + COL_W'(1);
    in_row_nx   = in_col_end ? ((in_row_inc >= height_i) ? '0 : ROW_W'(in_row_inc))
                             : r_clamp;

    out_col_end = (WEFF_W'(oc_clamp) + WEFF_W'(1)) >= width_i;
    out_row_inc = HGT_W'(or_clamp) + HGT_W'(1);
    out_col_nx  = out_col_end ? '0 : oc_clamp + COL_W'(1);
    out_row_nx  = out_col_end ? ((out_row_inc >= height_i) ? '0 : ROW_W'(out_row_inc))
                              : or_clamp;

    fill_inc   = fill_q + FILL_W'(1);
    fill_cap   = FILL_W'(width_i) + FILL_W'(1);
    norm_emit  = fill_inc > fill_cap;
    flush_emit = (fill_q != '0) && (in_col_q == '0) && (in_row_q == '0);
    emit_o     = ctl_i.flush ? flush_emit : norm_emit;

    on_last_row = HGT_W'(or_clamp) == (height_i - HGT_W'(1));
    on_last_col = WEFF_W'(oc_clamp) == (width_i - WEFF_W'(1));
    interior    = (or_clamp != '0) && ((HGT_W'(or_clamp) + HGT_W'(2)) <= height_i) &&
                  (oc_clamp != '0) && ((FILL_W'(oc_clamp) + FILL_W'(2)) <= FILL_W'(width_i));

    rd_addr = ctl_i.flush ? oc_clamp : c_clamp;
    rd_en   = ctl_i.acc && ctl_i.step;
  end

  // Advance counters for an accepted item
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    fill_d    = fill_q;
    if (rd_en) begin
      if (!ctl_i.flush) begin
        in_col_d = in_col_nx;
        in_row_d = in_row_nx;
        if (norm_emit) begin
          fill_d    = fill_cap;
          out_col_d = out_col_nx;
          out_row_d = out_row_nx;
        end else begin
          fill_d = fill_inc;
        end
      end else if (flush_emit) begin
        fill_d    = fill_q - FILL_W'(1);
        out_col_d = out_col_nx;
        out_row_d = out_row_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      fill_q    <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      fill_q    <= fill_d;
    end
  end

  // Compute register: control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_step_q <= 1'b0;
      s1_emit_q <= 1'b0;
    end else if (ctl_i.acc) begin
      s1_step_q <= ctl_i.step;
      s1_emit_q <= emit_o;
    end else if (ctl_i.adv) begin
      s1_step_q <= 1'b0;
      s1_emit_q <= 1'b0;
    end
  end

  // Compute register: item details
  always_ff @(posedge clk_i) begin
    if (ctl_i.acc) begin
      s1_flush_q <= ctl_i.flush;
      s1_int_q   <= interior;
      s1_last_q  <= on_last_row && on_last_col;
      s1_sel_q   <= on_last_row;
      s1_addr_q  <= c_clamp;
    end
  end

  // Line memories: write the leaving item, read for the new one with bypass
  assign wr_en = ctl_i.adv && s1_step_q && !s1_flush_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line0_mem[s1_addr_q] <= pix_i;
      line1_mem[s1_addr_q] <= rd0_q;
    end
    if (rd_en) begin
      if (wr_en && (s1_addr_q == rd_addr)) begin
        rd0_q <= pix_i;
        rd1_q <= rd0_q;
      end else begin
        rd0_q <= line0_mem[rd_addr];
        rd1_q <= line1_mem[rd_addr];
      end
    end
  end

  // Shift the window by one column and apply the 3x3 rule
  always_comb begin
    win_nx[0] = win_q[1];
    win_nx[1] = win_q[2];
    win_nx[2] = rd1_q;
    win_nx[3] = win_q[4];
    win_nx[4] = win_q[5];
    win_nx[5] = rd0_q;
    win_nx[6] = win_q[7];
    win_nx[7] = win_q[8];
    win_nx[8] = pix_i;

    any_set   = 1'b0;
    any_clear = 1'b0;
    for (int k = 0; k < 9; k++) begin
      if (k != 4) begin
        if (win_nx[k] != '0) begin
          any_set = 1'b1;
        end else begin
          any_clear = 1'b1;
        end
      end
    end

    center = win_nx[4];
    morph  = center;
    if (s1_int_q) begin
      if (ctl_i.dilate) begin
        if ((center == '0) && any_set) morph = bm3_pkg::FG_VALUE;
      end else begin
        if ((center != '0) && any_clear) morph = '0;
      end
    end

    // Flush items pass the pending pixel raw from the line memories
    pix_o = s1_flush_q ? (s1_sel_q ? rd0_q : rd1_q) : morph;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (wr_en) begin
      win_q <= win_nx;
    end
  end

  assign res_o.emit = s1_step_q && s1_emit_q;
  assign res_o.last = s1_last_q;

endmodule

`default_nettype wire

FILE: design/binary_morphology_3x3.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary_morphology_3x3: streaming 3x3 binary dilate / erode / open / close
// Raster pixel stream in, processed pixel stream out. Open and close run
// two filter stages in cascade; dilate and erode use the first stage only.
// ----------------------------------------------------------------------------
//
//  channel  | direction | content
//  ---------+-----------+------------------------------------------------
//  s_axis   | in        | tdata: pixel_in[7:0]; tuser: flush
//  m_axis   | out       | tdata: pixel_out[7:0]; tlast: frame_last
//  cfg      | in        | cfg_we_i, cfg_idx_i, cfg_wdata_i (write only)
//
//  One item per clock sustained while m_axis keeps up. An item is
//  registered at acceptance, line memory data is read into registers at
//  that same edge, and its result goes to the output register when the
//  item leaves the compute register. Each stage holds W+1 pixels before it
//  starts to emit; flush items drain them after the last pixel of a frame.
//  Reset clears counters, fill counts, windows and valids; line memories
//  are left as they are and need no clearing pass.
//  With m_axis_tready low, one result waits in the output register and one
//  more item in the compute register before s_axis_tready drops.
//
module binary_morphology_3x3 #(
  parameter int MAX_WIDTH = bm3_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Input pixel stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [7:0]                       s_axis_tdata,   // [7:0] pixel_in
  input  wire logic                             s_axis_tuser,   // [0] flush
  // Output pixel stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [7:0]                            m_axis_tdata,   // [7:0] pixel_out
  output logic                                  m_axis_tlast,
  // Configuration writes
  input  wire logic                             cfg_we_i,
  input  wire logic [bm3_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [bm3_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W  = bm3_pkg::HGT_W;
  localparam int PIX_W  = bm3_pkg::PIX_W;

  // Configuration registers
  logic [bm3_pkg::CFG_WID_W-1:0]  width_q;
  logic [HGT_W-1:0]               height_q;
  logic [bm3_pkg::CFG_MODE_W-1:0] mode_q;

  logic [WEFF_W-1:0] width_eff;
  logic [HGT_W-1:0]  height_eff;
  logic              two_stage;

  // Pipeline control
  logic              acc, adv, s1_emit, s1_last;
  logic              s1_valid_q;
  logic [PIX_W-1:0]  s1_pix_q;
  logic              out_valid_q, out_last_q;
  logic [PIX_W-1:0]  out_pix_q;

  // Stage hookup
  bm3_pkg::bm3_ctl_t ctl1, ctl2;
  bm3_pkg::bm3_res_t res1, res2;
  logic              emit1;
  logic [PIX_W-1:0]  pix1, pix2, s1_pix_res;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bm3_pkg::WIDTH_RST;
      height_q <= bm3_pkg::HEIGHT_RST;
      mode_q   <= bm3_pkg::MODE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bm3_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i[bm3_pkg::CFG_WID_W-1:0];
        bm3_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_wdata_i[HGT_W-1:0];
        bm3_pkg::CFG_OPER_MODE:    mode_q   <= cfg_wdata_i[bm3_pkg::CFG_MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp frame size to the supported range
  always_comb begin
    if (width_q < bm3_pkg::CFG_WID_W'(3)) begin
      width_eff = WEFF_W'(3);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      width_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      width_eff = WEFF_W'(width_q);
    end
    if (height_q < HGT_W'(3)) begin
      height_eff = HGT_W'(3);
    end else if (32'(height_q) > 32'(bm3_pkg::MAX_HEIGHT)) begin
      height_eff = HGT_W'(bm3_pkg::MAX_HEIGHT);
    end else begin
      height_eff = height_q;
    end
  end

  assign two_stage = (mode_q == bm3_pkg::MODE_OPEN) || (mode_q == bm3_pkg::MODE_CLOSE);

  // Handshake: compute register moves on when its result has a place to go
  assign s1_emit       = two_stage ? res2.emit : res1.emit;
  assign s1_last       = two_stage ? res2.last : res1.last;
  assign s1_pix_res    = two_stage ? pix2 : pix1;
  assign adv           = s1_valid_q && (!s1_emit || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || adv;
  assign acc           = s_axis_tvalid && s_axis_tready;

  // Stage controls; the second stage sees a flush only if the first one drops it
  always_comb begin
    ctl1.acc    = acc;
    ctl1.adv    = adv;
    ctl1.step   = 1'b1;
    ctl1.flush  = s_axis_tuser;
    ctl1.dilate = (mode_q == bm3_pkg::MODE_DILATE) || (mode_q == bm3_pkg::MODE_CLOSE);

    ctl2.acc    = acc;
    ctl2.adv    = adv;
    ctl2.step   = two_stage && (emit1 || s_axis_tuser);
    ctl2.flush  = !emit1;
    ctl2.dilate = (mode_q == bm3_pkg::MODE_OPEN);
  end

  bm3_stage #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_stage1 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .width_i  (width_eff),
    .height_i (height_eff),
    .ctl_i    (ctl1),
    .pix_i    (s1_pix_q),
    .emit_o   (emit1),
    .res_o    (res1),
    .pix_o    (pix1)
  );

  bm3_stage #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_stage2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .width_i  (width_eff),
    .height_i (height_eff),
    .ctl_i    (ctl2),
    .pix_i    (pix1),
    .emit_o   (),
    .res_o    (res2),
    .pix_o    (pix2)
  );

  // Compute register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (acc) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Hold the accepted pixel for the compute cycle
  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_pix_q <= s_axis_tdata[PIX_W-1:0];
    end
  end

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && s1_emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_emit) begin
      out_pix_q  <= s1_pix_res;
      out_last_q <= s1_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

FILE: design/bm3_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bm3_checker: port-level checks for the 3x3 morphology block
// Watches the stream handshakes on the top level and flags stall slips.
// ----------------------------------------------------------------------------
module bm3_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // Input back-pressure only comes from a blocked output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without an output stall");

  // A free output side always lets the next item in
  a_ready_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input not ready while output ready");

  // A refused input item means a result is waiting at the output
  a_in_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |-> m_axis_tvalid)
    else $error("item refused with no result pending");

endmodule

bind binary_morphology_3x3 bm3_checker u_bm3_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: bench/binary_morphology_3x3_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_morphology_3x3_tb: self-checking bench for the 3x3 morphology block
// Streams frames through all four operations and compares every output
// pixel against a cycle-free software copy of the two filter stages. It
// covers register clamping, small directed patterns, mid-frame flushes
// and broken frames, with random stalls on both streams.
// ----------------------------------------------------------------------------
module binary_morphology_3x3_tb;
  import bm3_pkg::*;

  localparam int          LINE_DEPTH      = MAX_WIDTH_DEF;
  localparam int          SETTLE_CYCLES   = 8;
  localparam longint      RUN_LIMIT_NS    = 40_000_000;
  localparam int          ITEM_TARGET     = 1450;
  localparam int          IDLE_FREE_ITEMS = 250;
  localparam int          PREFILL_WIDTH   = 40;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } pixel_result_t;

  // Software copy of the filter cascade plus the queue of pixels it predicts
  class morph_scoreboard;
    logic [CFG_WID_W-1:0]  width_reg;
    logic [HGT_W-1:0]      height_reg;
    logic [CFG_MODE_W-1:0] mode_reg;
    logic [PIX_W-1:0]      line_mem [2][2*LINE_DEPTH];
    logic [PIX_W-1:0]      win [2][9];
    int unsigned           in_col [2];
    int unsigned           in_row [2];
    int unsigned           out_col [2];
    int unsigned           out_row [2];
    int unsigned           fill [2];
    pixel_result_t         pending_pixels [$];
    int                    failures;
    int                    checked;
    int                    pixel_items;
    int                    flush_items;

    function new();
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      mode_reg   = MODE_RST;
      for (int s = 0; s < 2; s++) begin
        for (int i = 0; i < 2*LINE_DEPTH; i++) line_mem[s][i] = '0;
        for (int i = 0; i < 9; i++) win[s][i] = '0;
        in_col[s] = 0; in_row[s] = 0; out_col[s] = 0; out_row[s] = 0; fill[s] = 0;
      end
      failures = 0; checked = 0; pixel_items = 0; flush_items = 0;
    endfunction

    function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_IMAGE_WIDTH:  width_reg  = val[CFG_WID_W-1:0];
        CFG_IMAGE_HEIGHT: height_reg = val[HGT_W-1:0];
        CFG_OPER_MODE:    mode_reg   = val[CFG_MODE_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned row_length();
      if (width_reg < 3) return 3;
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return 32'(width_reg);
    endfunction

    function int unsigned frame_rows();
      if (height_reg < 3) return 3;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return 32'(height_reg);
    endfunction

    function bit is_cascade();
      return mode_reg == MODE_OPEN || mode_reg == MODE_CLOSE;
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction

    function int sent_items();
      return pixel_items + flush_items;
    endfunction

    // True while a finished frame still has pixels held in a stage
    function bit tail_pending();
      return fill[0] != 0 || (is_cascade() && fill[1] != 0);
    endfunction

    function void next_position(input int unsigned c, r, w, h,
                                output int unsigned nc, nr);
      nc = c + 1;
      nr = r;
      if (nc >= w) begin
        nc = 0;
        nr = r + 1;
        if (nr >= h) nr = 0;
      end
    endfunction

    // One filter stage: returns 1 when it emits a pixel for this item
    function bit filter_stage(int s, bit is_flush, logic [PIX_W-1:0] pin, bit dilate,
                              output logic [PIX_W-1:0] pout, output bit plast);
      int unsigned w, h, oc, orow, c, nc, nr;
      logic [PIX_W-1:0] top, mid, v;
      bit any_set, any_clear;
      w = row_length();
      h = frame_rows();
      oc = out_col[s];
      orow = out_row[s];
      pout = '0;
      plast = 1'b0;
      if (oc >= w) oc = 0;
      if (orow >= h) orow = 0;
      if (!is_flush) begin
        c = in_col[s];
        if (c >= w) c = 0;
        if (in_row[s] >= h) in_row[s] = 0;
        // Shift the line delays and the window by one pixel
        top = line_mem[s][LINE_DEPTH + c];
        mid = line_mem[s][c];
        line_mem[s][LINE_DEPTH + c] = mid;
        line_mem[s][c] = pin;
        for (int k = 0; k < 3; k++) begin
          win[s][k*3]   = win[s][k*3 + 1];
          win[s][k*3+1] = win[s][k*3 + 2];
        end
        win[s][2] = top;
        win[s][5] = mid;
        win[s][8] = pin;
        next_position(c, in_row[s], w, h, nc, nr);
        in_col[s] = nc;
        in_row[s] = nr;
        fill[s]++;
        if (fill[s] <= w + 1) return 1'b0;
        fill[s] = w + 1;
        // Interior pixels get the 3x3 rule, the border passes raw
        v = win[s][4];
        if (orow >= 1 && orow + 2 <= h && oc >= 1 && oc + 2 <= w) begin
          any_set = 1'b0;
          any_clear = 1'b0;
          for (int k = 0; k < 9; k++) begin
            if (k != 4) begin
              if (win[s][k] != 0) any_set = 1'b1;
              else any_clear = 1'b1;
            end
          end
          if (dilate) begin
            if (v == 0 && any_set) v = FG_VALUE;
          end else begin
            if (v != 0 && any_clear) v = '0;
          end
        end
      end else begin
        // Flush drains only at a frame boundary with pixels held
        if (fill[s] == 0 || in_col[s] != 0 || in_row[s] != 0) return 1'b0;
        v = (orow == h - 1) ? line_mem[s][oc] : line_mem[s][LINE_DEPTH + oc];
        fill[s]--;
      end
      pout = v;
      plast = (orow == h - 1) && (oc == w - 1);
      next_position(oc, orow, w, h, nc, nr);
      out_col[s] = nc;
      out_row[s] = nr;
      return 1'b1;
    endfunction

    // Note an accepted input item and queue the pixel it causes, if any
    function void note_input(logic [PIX_W-1:0] pin, bit is_flush);
      logic [PIX_W-1:0] v1, v2;
      bit l1, l2, got1, got2;
      pixel_result_t r;
      if (is_flush) flush_items++;
      else pixel_items++;
      got1 = filter_stage(0, is_flush, pin,
                          mode_reg == MODE_DILATE || mode_reg == MODE_CLOSE, v1, l1);
      if (is_cascade()) begin
        got2 = 1'b0;
        if (got1) got2 = filter_stage(1, 1'b0, v1, mode_reg == MODE_OPEN, v2, l2);
        else if (is_flush) got2 = filter_stage(1, 1'b1, '0, mode_reg == MODE_OPEN, v2, l2);
        if (got2) begin
          r.pixel = v2;
          r.last = l2;
          pending_pixels = {pending_pixels, r};
        end
      end else if (got1) begin
        r.pixel = v1;
        r.last = l1;
        pending_pixels = {pending_pixels, r};
      end
    endfunction

    // Compare an output pixel with the oldest prediction
    function void check_result(logic [PIX_W-1:0] pix, logic plast);
      pixel_result_t exp_r;
      if (pending_pixels.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("ERROR: unexpected output pixel %0d last %0b", pix, plast);
        return;
      end
      exp_r = pending_pixels.pop_front();
      checked++;
      if (exp_r.pixel !== pix || exp_r.last !== plast) begin
        failures++;
        if (failures <= 10)
          $display("ERROR: output %0d: expected pixel %0d last %0b, got pixel %0d last %0b",
                   checked, exp_r.pixel, exp_r.last, pix, plast);
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;   // [7:0] pixel_in
  logic                  s_axis_tuser = 1'b0; // [0] flush
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;        // [7:0] pixel_out
  logic                  m_axis_tlast;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  bit                    idle_on = 1'b0;
  int                    stall_left = 0;
  int                    frames = 0;
  int                    random_pixels = 0;
  morph_scoreboard       sb;

  binary_morphology_3x3 uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Receiver: stall in random bursts while idling is on
  always @(negedge clk_i) begin
    if (!idle_on) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 18);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Check every accepted output pixel
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tlast);
  end

  // Hard stop
  initial begin
    #(RUN_LIMIT_NS);
    $display("ERROR: run did not finish in time");
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [7:0] pick_pixel(int density);
    if ($urandom_range(0, 99) >= density) return 8'd0;
    if ($urandom_range(0, 3) == 0) return 8'd255;
    return 8'($urandom_range(1, 255));
  endfunction

  // Offer one item; returns at the falling edge after it is accepted
  task automatic send_item(input logic [7:0] pix, input bit is_flush);
    int gap;
    if (idle_on && $urandom_range(0, 11) == 0) begin
      gap = $urandom_range(1, 19);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= is_flush;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(pix, is_flush);
    @(negedge clk_i);
  endtask

  // Stop sending and wait until every predicted pixel has come out
  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.apply_register(idx, val);
    @(negedge clk_i);
  endtask

  // Write all three registers; the block must be idle
  task automatic program_frame(input logic [CFG_DATA_W-1:0] wv, hv,
                               input logic [CFG_MODE_W-1:0] mode);
    write_reg(CFG_IMAGE_WIDTH, wv);
    write_reg(CFG_IMAGE_HEIGHT, hv);
    write_reg(CFG_OPER_MODE, CFG_DATA_W'(mode));
    cfg_we_i <= 1'b0;
  endtask

  // Push out the tail of a finished frame with flush items
  task automatic drain_tail();
    int guard;
    guard = 2 * (sb.row_length() + 1) + 4;
    while (sb.tail_pending() && guard > 0) begin
      send_item(8'($urandom_range(0, 255)), 1'b1);
      guard--;
    end
  endtask

  // Send count pixels of random content, optionally with stray flushes
  // and one pause until the output side has caught up
  task automatic send_random_frame(input int count, input int density,
                                   input bit noise, input bit pause);
    int pause_at;
    pause_at = pause ? $urandom_range(1, count - 1) : -1;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) hold_until_drained();
      if (noise && $urandom_range(0, 24) == 0)
        send_item(8'($urandom_range(0, 255)), 1'b1);
      send_item(pick_pixel(density), 1'b0);
    end
    frames++;
  endtask

  // 3x3 frame from a packed pattern, pixel k in bits [8k+7:8k];
  // a flush in the middle of the frame must be ignored
  task automatic send_pattern(input logic [71:0] pattern);
    for (int k = 0; k < 9; k++) begin
      if (k == 4) send_item(8'($urandom_range(0, 255)), 1'b1);
      send_item(pattern[8*k +: 8], 1'b0);
    end
    frames++;
    drain_tail();
    hold_until_drained();
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] wv, hv;
    logic [CFG_MODE_W-1:0] mode;
    int group_frames, count;

    sb = new();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    idle_on <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Widest line used later, shortest frame (height clamped up) in close
    // mode: writes every line entry that later frames read, in both stages
    program_frame(CFG_DATA_W'(PREFILL_WIDTH), 13'd0, MODE_CLOSE);
    send_random_frame(sb.row_length() * sb.frame_rows(), 50, 1'b0, 1'b0);
    drain_tail();
    hold_until_drained();

    // Dilate: only the upper-right neighbor is set, so the center turns on;
    // a flush with nothing held comes first and must be ignored
    program_frame(13'd3, 13'd3, MODE_DILATE);
    send_item(8'hA5, 1'b1);
    send_pattern(72'h00_0000_0000_0001_0000);

    // Erode: everything set except the upper-right neighbor
    program_frame(13'd3, 13'd3, MODE_ERODE);
    send_pattern({{6{8'hC8}}, 8'h00, 8'h80, 8'h01});

    // Dilate with all zero, erode with all full: nothing changes
    program_frame(13'd3, 13'd3, MODE_DILATE);
    send_pattern(72'h0);
    program_frame(13'd3, 13'd3, MODE_ERODE);
    send_pattern({9{8'hFF}});

    // Cascaded modes on a small frame
    program_frame(13'd5, 13'd5, MODE_OPEN);
    send_random_frame(25, 60, 1'b0, 1'b0);
    drain_tail();
    hold_until_drained();
    program_frame(13'd5, 13'd5, MODE_CLOSE);
    send_random_frame(25, 40, 1'b0, 1'b0);
    drain_tail();
    hold_until_drained();

    // Random frames: mostly whole frames, some stray flushes and cut frames
    while (sb.sent_items() < ITEM_TARGET) begin
      case ($urandom_range(0, 19))
        0:       wv = CFG_DATA_W'($urandom_range(0, 2));
        1, 2:    wv = CFG_DATA_W'($urandom_range(9, PREFILL_WIDTH));
        default: wv = CFG_DATA_W'($urandom_range(3, 8));
      endcase
      case ($urandom_range(0, 9))
        0:       hv = CFG_DATA_W'($urandom_range(0, 2));
        1:       hv = CFG_DATA_W'($urandom_range(8, 12));
        default: hv = CFG_DATA_W'($urandom_range(3, 6));
      endcase
      mode = CFG_MODE_W'($urandom_range(0, 3));
      idle_on <= (sb.sent_items() < ITEM_TARGET - IDLE_FREE_ITEMS) &&
                 ($urandom_range(0, 3) != 0);
      program_frame(wv, hv, mode);
      group_frames = $urandom_range(1, 3);
      for (int f = 0; f < group_frames; f++) begin
        count = sb.row_length() * sb.frame_rows();
        if ($urandom_range(0, 9) == 0) count = $urandom_range(1, count - 1);
        send_random_frame(count, 10 + 20 * $urandom_range(0, 4),
                          $urandom_range(0, 3) == 0,
                          random_pixels == 0 || $urandom_range(0, 9) == 0);
        random_pixels += count;
        drain_tail();
      end
      hold_until_drained();
    end

    repeat (20) @(negedge clk_i);
    if (sb.pending() != 0) begin
      $display("ERROR: %0d predicted pixels never came out", sb.pending());
      sb.failures += sb.pending();
    end
    $display("Sent %0d pixel and %0d flush items in %0d frames over all four modes,",
             sb.pixel_items, sb.flush_items, frames);
    $display("widths 3 to 40, heights 3 to 12 with clamping; checked %0d pixels, %0d errors.",
             sb.checked, sb.failures);
    if (sb.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/bm3_pkg.sv
design/bm3_stage.sv
design/binary_morphology_3x3.sv
design/bm3_checker.sv
bench/binary_morphology_3x3_tb.sv
